// ----- hw/rtl/prts_pkg.sv -----
package prts_pkg;

	localparam int MaxTasksDef       = 8;
	localparam int PriorityLevelsDef = 4;
	localparam int DelayWidthDef     = 32;

	localparam int CmdW     = 3;
	localparam int TaskIdW  = 3;
	localparam int DelayInW = 32;
	localparam int TaskOutW = 4;
	localparam int CountW   = 4;
	localparam int PrioW    = 24;
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 24;

	localparam logic [CfgIdxW-1:0] CFG_TASK_COUNT = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_TASK_PRIO  = 1'b1;

	typedef enum logic [CmdW-1:0] {
		CMD_START  = 3'd0,
		CMD_TICK   = 3'd1,
		CMD_SCHED  = 3'd2,
		CMD_BLOCK  = 3'd3,
		CMD_COMMIT = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_READY   = 2'd0,
		ST_BLOCKED = 2'd1,
		ST_RUNNING = 2'd2
	} run_state_t;

	typedef enum logic [1:0] {
		PH_UNSTARTED = 2'd0,
		PH_FROM_RESET = 2'd1,
		PH_NORMAL    = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		FSM_IDLE,
		FSM_BUILD,
		FSM_TICK_RD,
		FSM_TICK_WR,
		FSM_LVL,
		FSM_MEM_RD,
		FSM_STATE_RD,
		FSM_DECIDE,
		FSM_COMMIT_RD,
		FSM_DONE
	} fsm_t;

endpackage

// ----- hw/rtl/priority_round_robin_task_scheduler.sv -----
// Channel  | Ports                                            | Transfer
// ---------+--------------------------------------------------+------------------------------
// command  | start, busy, cmd, task_id, delay_ticks           | clk edge with start=1, busy=0
// result   | done, pick_task, run_task, switch_needed, error  | one-cycle strobe on done
// config   | cfg_we, cfg_index, cfg_data                      | clk edge with cfg_we=1
//
// Busy holds from a command's transfer until FSM_IDLE; done strobes as busy drops. The
// receiver cannot stall. A tick sweeps the active tasks through the delay memory, a read
// and a write per task, then walks the levels: a member visit passes the level, member
// read, state read and decide states, an empty level only the level state. Start fills
// the level tables one task a cycle over all MAX_TASKS slots. Reset clears control state
// at once; start clears the task memories and fills the member memory.
module priority_round_robin_task_scheduler #(
	parameter int MAX_TASKS       = prts_pkg::MaxTasksDef,
	parameter int PRIORITY_LEVELS = prts_pkg::PriorityLevelsDef,
	parameter int DELAY_WIDTH     = prts_pkg::DelayWidthDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [prts_pkg::CmdW-1:0]      cmd,
	input  logic [prts_pkg::TaskIdW-1:0]   task_id,
	input  logic [prts_pkg::DelayInW-1:0]  delay_ticks,
	output logic                           done,
	output logic [prts_pkg::TaskOutW-1:0]  pick_task,
	output logic [prts_pkg::TaskOutW-1:0]  run_task,
	output logic                           switch_needed,
	output logic                           error,
	input  logic                           cfg_we,
	input  logic [prts_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [prts_pkg::CfgDataW-1:0]  cfg_data
);

	localparam int TW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;   // task index
	localparam int TCW = $clog2(MAX_TASKS + 1);                      // task count
	localparam int LW  = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
	localparam int LCW = $clog2(PRIORITY_LEVELS + 1);
	localparam int MW  = LW + TW;
	localparam int MEMD = PRIORITY_LEVELS * MAX_TASKS;
	localparam logic [TCW-1:0] IDLE = TCW'(MAX_TASKS);

	// configuration registers
	logic [prts_pkg::CountW-1:0] task_count_q;
	logic [prts_pkg::PrioW-1:0]  task_prio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= '0;
			task_prio_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				prts_pkg::CFG_TASK_COUNT: task_count_q <= cfg_data[prts_pkg::CountW-1:0];
				prts_pkg::CFG_TASK_PRIO:  task_prio_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// memories: per-task state and delay, level membership
	logic [1:0]             state_mem [MAX_TASKS];
	logic [DELAY_WIDTH-1:0] delay_mem [MAX_TASKS];
	logic [TW-1:0]          member_mem [MEMD];

	logic          st_we;
	logic [TW-1:0] st_waddr, st_raddr;
	logic [1:0]    st_wdata, st_rdata_q;
	logic          dl_we;
	logic [TW-1:0] dl_addr;
	logic [DELAY_WIDTH-1:0] dl_wdata, dl_rdata_q;
	logic          mb_we;
	logic [MW-1:0] mb_waddr, mb_raddr;
	logic [TW-1:0] mb_wdata, mb_rdata_q;

	always_ff @(posedge clk) begin
		if (st_we) state_mem[st_waddr] <= st_wdata;
		st_rdata_q <= state_mem[st_raddr];
		if (dl_we) delay_mem[dl_addr] <= dl_wdata;
		dl_rdata_q <= delay_mem[dl_addr];
		if (mb_we) member_mem[mb_waddr] <= mb_wdata;
		mb_rdata_q <= member_mem[mb_raddr];
	end

	// control state
	prts_pkg::fsm_t   fsm_q, fsm_d;
	prts_pkg::phase_t phase_q, phase_d;
	logic [TCW-1:0] running_q, running_d, chosen_q, chosen_d;
	logic           pend_q, pend_d;
	logic [TCW-1:0] active_q, active_d;
	logic [TCW-1:0] lcount_q [PRIORITY_LEVELS];
	logic [TCW-1:0] lcount_d [PRIORITY_LEVELS];
	logic [TW-1:0]  lrot_q [PRIORITY_LEVELS];
	logic [TW-1:0]  lrot_d [PRIORITY_LEVELS];
	logic [TCW-1:0] lcnt_q [PRIORITY_LEVELS];  // blocked seen per level
	logic [TCW-1:0] lcnt_d [PRIORITY_LEVELS];
	logic [TCW-1:0] idx_q, idx_d;              // sweep index
	logic [LCW-1:0] lvl_q, lvl_d;
	logic [TW-1:0]  vidx_q, vidx_d;            // rotation slot being visited
	logic           err_q, err_d;
	logic           done_q, done_d;
	prts_pkg::cmd_t cmd_q, cmd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q     <= prts_pkg::FSM_IDLE;
			phase_q   <= prts_pkg::PH_UNSTARTED;
			running_q <= IDLE;
			chosen_q  <= IDLE;
			pend_q    <= 1'b0;
			active_q  <= '0;
			for (int l = 0; l < PRIORITY_LEVELS; l++) begin
				lcount_q[l] <= '0;
				lrot_q[l]   <= '0;
				lcnt_q[l]   <= '0;
			end
			idx_q  <= '0;
			lvl_q  <= '0;
			vidx_q <= '0;
			err_q  <= 1'b0;
			done_q <= 1'b0;
			cmd_q  <= prts_pkg::CMD_START;
		end else begin
			fsm_q     <= fsm_d;
			phase_q   <= phase_d;
			running_q <= running_d;
			chosen_q  <= chosen_d;
			pend_q    <= pend_d;
			active_q  <= active_d;
			lcount_q  <= lcount_d;
			lrot_q    <= lrot_d;
			lcnt_q    <= lcnt_d;
			idx_q     <= idx_d;
			lvl_q     <= lvl_d;
			vidx_q    <= vidx_d;
			err_q     <= err_d;
			done_q    <= done_d;
			cmd_q     <= cmd_d;
		end
	end

	// priority of the task at idx_q, clamped; tasks beyond the field get level 0
	logic [2:0]    prio_raw;
	logic [LW-1:0] prio_lvl;
	always_comb begin
		prio_raw = 3'd0;
		for (int i = 0; i < 8; i++)
			if (32'(idx_q) == 32'(i)) prio_raw = task_prio_q[3*i +: 3];
		if (32'(prio_raw) >= PRIORITY_LEVELS) prio_lvl = LW'(PRIORITY_LEVELS - 1);
		else prio_lvl = LW'(prio_raw);
	end

	logic [TCW-1:0] cnt_clamp;
	assign cnt_clamp = (32'(task_count_q) > MAX_TASKS) ? IDLE : TCW'(task_count_q);

	logic [LW-1:0]  lvl_idx;
	logic [TCW-1:0] cur_lcount;
	logic [TW-1:0]  rot_use;
	assign lvl_idx    = lvl_q[LW-1:0];
	assign cur_lcount = lcount_q[lvl_idx];
	assign rot_use    = (32'(lrot_q[lvl_idx]) >= 32'(cur_lcount)) ? '0 : lrot_q[lvl_idx];

	// next state and datapath
	always_comb begin
		fsm_d     = fsm_q;
		phase_d   = phase_q;
		running_d = running_q;
		chosen_d  = chosen_q;
		pend_d    = pend_q;
		active_d  = active_q;
		lcount_d  = lcount_q;
		lrot_d    = lrot_q;
		lcnt_d    = lcnt_q;
		idx_d     = idx_q;
		lvl_d     = lvl_q;
		vidx_d    = vidx_q;
		err_d     = err_q;
		done_d    = 1'b0;
		cmd_d     = cmd_q;
		st_we = 1'b0; st_waddr = idx_q[TW-1:0]; st_wdata = prts_pkg::ST_READY;
		st_raddr = idx_q[TW-1:0];
		dl_we = 1'b0; dl_addr = idx_q[TW-1:0]; dl_wdata = '0;
		mb_we = 1'b0; mb_waddr = '0; mb_wdata = idx_q[TW-1:0];
		mb_raddr = MW'(32'(lvl_idx) * MAX_TASKS + 32'(rot_use));
		busy = (fsm_q != prts_pkg::FSM_IDLE);

		unique case (fsm_q)
			prts_pkg::FSM_IDLE: begin
				if (start) begin
					err_d = 1'b0;
					idx_d = '0;
					lvl_d = '0;
					for (int l = 0; l < PRIORITY_LEVELS; l++) lcnt_d[l] = '0;
					fsm_d = prts_pkg::FSM_DONE;
					if (cmd == prts_pkg::CMD_START) begin
						cmd_d    = prts_pkg::CMD_START;
						active_d = cnt_clamp;
						for (int l = 0; l < PRIORITY_LEVELS; l++) begin
							lcount_d[l] = '0;
							lrot_d[l]   = '0;
						end
						phase_d   = prts_pkg::PH_FROM_RESET;
						running_d = IDLE;
						chosen_d  = IDLE;
						pend_d    = 1'b1;
						fsm_d     = prts_pkg::FSM_BUILD;
					end else if (phase_q != prts_pkg::PH_UNSTARTED) begin
						priority case (cmd)
							prts_pkg::CMD_TICK: begin
								cmd_d = prts_pkg::CMD_TICK;
								fsm_d = (active_q == '0) ? prts_pkg::FSM_LVL
									: prts_pkg::FSM_TICK_RD;
							end
							prts_pkg::CMD_SCHED: fsm_d = prts_pkg::FSM_LVL;
							prts_pkg::CMD_BLOCK: begin
								if (32'(task_id) >= 32'(active_q)) begin
									err_d = 1'b1;
								end else begin
									st_we    = 1'b1;
									st_waddr = task_id[TW-1:0];
									st_wdata = prts_pkg::ST_BLOCKED;
									dl_we    = 1'b1;
									dl_addr  = task_id[TW-1:0];
									dl_wdata = delay_ticks[DELAY_WIDTH-1:0];
									fsm_d    = prts_pkg::FSM_LVL;
								end
							end
							prts_pkg::CMD_COMMIT: begin
								if (pend_q) begin
									if (phase_q == prts_pkg::PH_FROM_RESET) begin
										running_d = IDLE;
										phase_d   = prts_pkg::PH_NORMAL;
										pend_d    = 1'b0;
									end else if (running_q != IDLE) begin
										st_raddr = running_q[TW-1:0];
										fsm_d    = prts_pkg::FSM_COMMIT_RD;
									end else begin
										running_d = chosen_q;
										pend_d    = 1'b0;
										if (chosen_q != IDLE) begin
											st_we    = 1'b1;
											st_waddr = chosen_q[TW-1:0];
											st_wdata = prts_pkg::ST_RUNNING;
										end
									end
								end
							end
							default: ;
						endcase
					end
				end
			end

			prts_pkg::FSM_BUILD: begin
				// reset one task and, if it is active, file it into its level
				if (idx_q < IDLE) begin
					st_we    = 1'b1;
					st_wdata = prts_pkg::ST_READY;
					dl_we    = 1'b1;
					dl_wdata = '0;
				end
				if (idx_q < active_q) begin
					mb_we    = 1'b1;
					mb_waddr = MW'(32'(prio_lvl) * MAX_TASKS + 32'(lcount_q[prio_lvl]));
					lcount_d[prio_lvl] = lcount_q[prio_lvl] + 1'b1;
				end
				if (idx_q == IDLE - 1'b1) fsm_d = prts_pkg::FSM_DONE;
				idx_d = idx_q + 1'b1;
			end

			prts_pkg::FSM_TICK_RD: begin
				fsm_d = prts_pkg::FSM_TICK_WR;
			end

			prts_pkg::FSM_TICK_WR: begin
				if (dl_rdata_q != '0) begin
					dl_we    = 1'b1;
					dl_wdata = dl_rdata_q - 1'b1;
				end
				if ((dl_rdata_q == '0 || dl_rdata_q == DELAY_WIDTH'(1))
					&& st_rdata_q == prts_pkg::ST_BLOCKED) begin
					st_we    = 1'b1;
					st_wdata = prts_pkg::ST_READY;
				end
				idx_d = idx_q + 1'b1;
				fsm_d = (idx_q + 1'b1 >= active_q) ? prts_pkg::FSM_LVL
					: prts_pkg::FSM_TICK_RD;
			end

			prts_pkg::FSM_LVL: begin
				if (phase_q == prts_pkg::PH_FROM_RESET) begin
					running_d = IDLE;
					chosen_d  = IDLE;
					pend_d    = 1'b1;
					for (int l = 0; l < PRIORITY_LEVELS; l++) lrot_d[l] = '0;
					fsm_d = prts_pkg::FSM_DONE;
				end else if (32'(lvl_q) >= PRIORITY_LEVELS) begin
					chosen_d = IDLE;
					pend_d   = 1'b1;
					fsm_d    = prts_pkg::FSM_DONE;
				end else if (cur_lcount == '0) begin
					lvl_d = lvl_q + 1'b1;
				end else begin
					vidx_d = rot_use;
					fsm_d  = prts_pkg::FSM_MEM_RD;
				end
			end

			prts_pkg::FSM_MEM_RD: begin
				st_raddr = mb_rdata_q;
				fsm_d    = prts_pkg::FSM_STATE_RD;
			end

			prts_pkg::FSM_STATE_RD: begin
				// hold the state address so the read data stays on the member task
				st_raddr = mb_rdata_q;
				fsm_d    = prts_pkg::FSM_DECIDE;
			end

			prts_pkg::FSM_DECIDE: begin
				// advance this level's rotation past the visited slot
				if (32'(vidx_q) + 1 >= 32'(cur_lcount)) lrot_d[lvl_idx] = '0;
				else lrot_d[lvl_idx] = vidx_q + 1'b1;
				fsm_d = prts_pkg::FSM_DONE;
				if (st_rdata_q == prts_pkg::ST_READY) begin
					chosen_d = TCW'(mb_rdata_q);
					pend_d   = 1'b1;
				end else if (st_rdata_q == prts_pkg::ST_RUNNING) begin
					pend_d = 1'b0;
				end else begin
					lcnt_d[lvl_idx] = lcnt_q[lvl_idx] + 1'b1;
					fsm_d = prts_pkg::FSM_LVL;
					if (32'(lcnt_q[lvl_idx]) + 1 >= 32'(cur_lcount)) lvl_d = lvl_q + 1'b1;
				end
			end

			prts_pkg::FSM_COMMIT_RD: begin
				if (st_rdata_q == prts_pkg::ST_RUNNING) begin
					st_we    = 1'b1;
					st_waddr = running_q[TW-1:0];
					st_wdata = prts_pkg::ST_READY;
				end
				fsm_d     = prts_pkg::FSM_DONE;
				running_d = chosen_q;
				pend_d    = 1'b0;
				if (chosen_q != IDLE) begin
					// a second write would collide; chosen is written in DONE
					cmd_d = prts_pkg::CMD_COMMIT;
				end
			end

			prts_pkg::FSM_DONE: begin
				if (cmd_q == prts_pkg::CMD_COMMIT) begin
					st_we    = 1'b1;
					st_waddr = running_q[TW-1:0];
					st_wdata = prts_pkg::ST_RUNNING;
					cmd_d    = prts_pkg::CMD_SCHED;
				end
				done_d = 1'b1;
				fsm_d  = prts_pkg::FSM_IDLE;
			end

			default: fsm_d = prts_pkg::FSM_IDLE;
		endcase

		// an immediate command completes in one pass through DONE too
		if (fsm_q == prts_pkg::FSM_DONE) cmd_d = prts_pkg::CMD_SCHED;
		if (fsm_q == prts_pkg::FSM_COMMIT_RD && chosen_q != IDLE) cmd_d = prts_pkg::CMD_COMMIT;
	end

	assign done          = done_q;
	assign pick_task     = prts_pkg::TaskOutW'(chosen_q);
	assign run_task      = prts_pkg::TaskOutW'(running_q);
	assign switch_needed = pend_q;
	assign error         = err_q;

endmodule
